// File: hdl/tga_pkg.sv
// types and constants shared by the targa rle decoder
`timescale 1ns / 1ps
package tga_pkg;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned HDR_KIND   = 7;
  localparam logic [6:0]  COUNT_MASK = 7'd127;
  localparam logic [7:0]  MAX_RUN    = 8'd128;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned IMG_W      = 25;

  localparam logic        REG_BPP    = 1'b0;
  localparam logic        REG_IMG    = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               is_repeat;
    logic [COUNT_W-1:0] count;
    logic               eop;
  } cmd_t;

endpackage

// File: hdl/tga_if.sv
// request channels: stream bytes in, decoded pixels out
`timescale 1ns / 1ps
interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport monitor (input valid, input data_byte, input ready);
endinterface

interface tga_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic [1:0]  copies;
  logic        last_of_run;
  logic        image_done;
  modport source (output valid, output pixel, output copies, output last_of_run,
                  output image_done, input ready);
  modport sink (input valid, input pixel, input copies, input last_of_run,
                input image_done, output ready);
  modport monitor (input valid, input pixel, input copies, input last_of_run,
                   input image_done, input ready);
endinterface

// File: hdl/tga_rle_pixel_decoder_top.sv
// top level of the targa rle pixel decoder
`timescale 1ns / 1ps
// usage:
// - in_ch carries one compressed byte per request; headers and pixel bytes
//   share the channel. header bytes are always taken at once.
// - out_ch carries decoded pixels, each request worth one or two copies.
//   a repeat packet gives up to 64 requests, a literal pixel one.
// - cfg_we/cfg_index/cfg_data write bytes_per_pixel (0) and image_pixels (1);
//   write only while no bytes are in flight.
// - path: a completed pixel is registered in the command queue and then in
//   the output register; a repeat run first passes the back end's run state.
// - throughput: one input byte per cycle while the two-entry command queue
//   has room; a repeat run then holds the back end while it issues
//   ceil(n/2) requests, n clipped to the pixels left in the image.
// - when the receiver stalls, the output register holds, the queue fills and
//   in_ch.ready drops for pixel bytes.
// - reset (rst, synchronous) clears the parser, the queue, the pixel count
//   and the output valid; registers return to 4 bytes per pixel, 1 pixel.
module tga_rle_pixel_decoder_top
  import tga_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS    = 24,
  parameter int MAX_BYTES_PER_PIXEL = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [IMG_W-1:0] cfg_data,
  tga_byte_if.sink         in_ch,
  tga_pix_if.source        out_ch
);

  localparam int CW = PIXEL_COUNT_BITS + 1;
  localparam int WW = (CW > IMG_W) ? CW : IMG_W;

  logic [BPP_W-1:0] bytes_per_pixel;
  logic [IMG_W-1:0] image_pixels;
  logic [BPP_W-1:0] bpp_eff;
  logic [WW-1:0]    img_w;
  logic [WW-1:0]    top_w;
  logic [WW-1:0]    lim_w;
  logic [CW-1:0]    limit;

  logic             f_valid;
  cmd_t             f_cmd;
  logic             f_ready;
  logic             b_valid;
  cmd_t             b_cmd;
  logic             b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(4);
      image_pixels    <= IMG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BPP: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_IMG: image_pixels    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bytes_per_pixel == '0) bpp_eff = BPP_W'(1);
    else if (bytes_per_pixel > BPP_W'(MAX_BYTES_PER_PIXEL)) bpp_eff = BPP_W'(MAX_BYTES_PER_PIXEL);
    else bpp_eff = bytes_per_pixel;
  end

  assign img_w = WW'(image_pixels);
  assign top_w = WW'(1) << PIXEL_COUNT_BITS;
  assign lim_w = (img_w == '0) ? WW'(1) : ((img_w > top_w) ? top_w : img_w);
  assign limit = lim_w[CW-1:0];

  tga_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bpp       (bpp_eff),
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  tga_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_cmd    (b_cmd),
    .pop_ready  (b_ready)
  );

  tga_back #(.CW(CW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .limit     (limit),
    .cmd_valid (b_valid),
    .cmd       (b_cmd),
    .cmd_ready (b_ready),
    .out_ch    (out_ch)
  );

endmodule

// File: hdl/tga_front.sv
// front end: packet header parsing and pixel byte assembly
`timescale 1ns / 1ps
module tga_front
  import tga_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [BPP_W-1:0] bpp,
  tga_byte_if.sink         in_ch,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_ready
);

  typedef enum logic {PH_HDR, PH_PIX} phase_t;

  phase_t             phase;
  logic               is_repeat;
  logic [COUNT_W-1:0] run_left;
  logic [1:0]         slot;
  logic [PIXEL_W-1:0] accum;

  logic               accept;
  logic               complete;
  logic [PIXEL_W-1:0] accum_next;
  logic [COUNT_W-1:0] run_left_next;
  logic               eop;

  assign in_ch.ready   = (phase == PH_HDR) || cmd_ready;
  assign accept        = in_ch.valid && in_ch.ready;
  assign complete      = ({1'b0, slot} + 3'd1) >= bpp;
  assign accum_next    = accum | ({{(PIXEL_W-8){1'b0}}, in_ch.data_byte} << {slot, 3'b000});
  assign run_left_next = run_left - COUNT_W'(1);
  assign eop           = is_repeat || (run_left_next == '0);

  assign cmd_valid     = accept && (phase == PH_PIX) && complete;
  assign cmd.pixel     = accum_next;
  assign cmd.is_repeat = is_repeat;
  assign cmd.count     = run_left;
  assign cmd.eop       = eop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR;
      slot  <= '0;
      accum <= '0;
    end else if (accept) begin
      case (phase)
        PH_HDR: begin
          run_left  <= {1'b0, in_ch.data_byte[6:0] & COUNT_MASK} + COUNT_W'(1);
          is_repeat <= in_ch.data_byte[HDR_KIND];
          slot      <= '0;
          accum     <= '0;
          phase     <= PH_PIX;
        end
        PH_PIX: begin
          if (!complete) begin
            slot  <= slot + 2'd1;
            accum <= accum_next;
          end else begin
            slot  <= '0;
            accum <= '0;
            if (!is_repeat) run_left <= run_left_next;
            if (eop) phase <= PH_HDR;
          end
        end
        default: phase <= PH_HDR;
      endcase
    end
  end

endmodule

// File: hdl/tga_queue.sv
// two-entry command queue between front and back end
`timescale 1ns / 1ps
module tga_queue
  import tga_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/tga_back.sv
// back end: run expansion, image pixel counting and output register
`timescale 1ns / 1ps
module tga_back
  import tga_pkg::*;
#(
  parameter int CW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] limit,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          cmd_ready,
  tga_pix_if.source     out_ch
);

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t            state;
  logic [CW-1:0]      written;
  logic               drop;
  logic [COUNT_W-1:0] n_left;
  logic               run_done;
  logic [PIXEL_W-1:0] run_px;

  logic               out_valid;
  logic [PIXEL_W-1:0] out_pixel;
  logic [1:0]         out_copies;
  logic               out_last;
  logic               out_done;

  logic               can_load;
  logic               load;
  logic [CW-1:0]      remaining;
  logic               rep_done;
  logic               lit_done;
  logic [1:0]         cp;
  logic [COUNT_W-1:0] n_next;

  assign can_load  = !out_valid || out_ch.ready;
  assign cmd_ready = (state == B_IDLE) && can_load;
  assign load      = ((state == B_IDLE) && cmd_valid && cmd_ready && !cmd.is_repeat && !drop) ||
                     ((state == B_RUN) && can_load);
  assign remaining = (written < limit) ? (limit - written) : CW'(1);
  assign rep_done  = CW'(cmd.count) >= remaining;
  assign lit_done  = (remaining == CW'(1));
  assign cp        = (n_left >= COUNT_W'(2)) ? 2'd2 : 2'd1;
  assign n_next    = n_left - COUNT_W'(cp);

  assign out_ch.valid       = out_valid;
  assign out_ch.pixel       = out_pixel;
  assign out_ch.copies      = out_copies;
  assign out_ch.last_of_run = out_last;
  assign out_ch.image_done  = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      written   <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            if (cmd.is_repeat) begin
              run_px   <= cmd.pixel;
              run_done <= rep_done;
              n_left   <= rep_done ? remaining[COUNT_W-1:0] : cmd.count;
              state    <= B_RUN;
            end else if (drop) begin
              if (cmd.eop) drop <= 1'b0;
            end else begin
              out_pixel  <= cmd.pixel;
              out_copies <= 2'd1;
              out_last   <= 1'b1;
              out_done   <= lit_done;
              written    <= lit_done ? '0 : written + CW'(1);
              if (lit_done && !cmd.eop) drop <= 1'b1;
            end
          end
        end
        B_RUN: begin
          if (can_load) begin
            out_pixel  <= run_px;
            out_copies <= cp;
            out_last   <= (n_next == '0);
            out_done   <= (n_next == '0) && run_done;
            if ((n_next == '0) && run_done) written <= '0;
            else written <= written + CW'(cp);
            n_left <= n_next;
            if (n_next == '0) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/tga_chk.sv
// port checker for the targa rle pixel decoder and its bind
`timescale 1ns / 1ps
module tga_chk (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [31:0] pixel,
  input logic [1:0]  copies,
  input logic        last_of_run,
  input logic        image_done
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("output request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> $stable(pixel) && $stable(copies))
    else $error("output payload changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    valid && image_done |-> last_of_run)
    else $error("image completed on a request that is not last of its run");

  a_copies: assert property (@(posedge clk) disable iff (rst)
    valid |-> (copies == 2'd1 || copies == 2'd2))
    else $error("copy count out of range");

  a_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("output valid after reset");

endmodule

bind tga_rle_pixel_decoder_top tga_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .valid       (out_ch.valid),
  .ready       (out_ch.ready),
  .pixel       (out_ch.pixel),
  .copies      (out_ch.copies),
  .last_of_run (out_ch.last_of_run),
  .image_done  (out_ch.image_done)
);

// File: sim/tga_rle_pixel_decoder_top_test.sv
// self-checking testbench for the targa rle pixel decoder
`timescale 1ns / 1ps
module tga_rle_pixel_decoder_top_test;
  import tga_pkg::*;

  localparam int          COUNT_BITS    = 24;
  localparam int          MAX_BPP       = 4;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef enum logic [1:0] {HDR_WAIT, RUN_PIXEL, LIT_PIXEL, LIT_SKIP} parse_phase_t;

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic [1:0]         copies;
    logic               last_of_run;
    logic               image_done;
  } decoded_px_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [IMG_W-1:0] cfg_data;

  tga_byte_if byte_ch ();
  tga_pix_if  pix_ch ();

  tga_rle_pixel_decoder_top #(
    .PIXEL_COUNT_BITS    (COUNT_BITS),
    .MAX_BYTES_PER_PIXEL (MAX_BPP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (byte_ch),
    .out_ch    (pix_ch)
  );

  decoded_px_t       pending_pixels[$];
  decoded_px_t       want_px;
  logic [BPP_W-1:0]  bpp_reg;
  logic [IMG_W-1:0]  img_reg;
  parse_phase_t      parse_phase;
  int unsigned       run_left;
  int unsigned       byte_slot;
  logic [31:0]       pixel_acc;
  longint unsigned   pixels_out;
  int unsigned       error_count;
  int unsigned       bytes_fed;
  int unsigned       cycle_count;
  int unsigned       stall_left;
  bit                idle_en;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned eff_bpp();
    int unsigned b;
    b = bpp_reg;
    if (b == 0) b = 1;
    if (b > MAX_BPP) b = MAX_BPP;
    return b;
  endfunction

  function automatic longint unsigned pixels_left();
    longint unsigned lim;
    lim = img_reg;
    if (lim == 0) lim = 1;
    if (lim > (64'd1 << COUNT_BITS)) lim = 64'd1 << COUNT_BITS;
    return (pixels_out < lim) ? lim - pixels_out : 1;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    longint unsigned rem;
    longint unsigned n;
    int unsigned     cp;
    logic [31:0]     px;
    bit              done;
    decoded_px_t     r;
    if (parse_phase == HDR_WAIT) begin
      run_left    = int'(b[6:0] & COUNT_MASK) + 1;
      byte_slot   = 0;
      pixel_acc   = '0;
      parse_phase = b[HDR_KIND] ? RUN_PIXEL : LIT_PIXEL;
      return;
    end
    pixel_acc = pixel_acc | ({24'd0, b} << (8 * (byte_slot % 4)));
    if (byte_slot + 1 < eff_bpp()) begin
      byte_slot = (byte_slot + 1) % 4;
      return;
    end
    px        = pixel_acc;
    byte_slot = 0;
    pixel_acc = '0;
    if (parse_phase == RUN_PIXEL) begin
      rem = pixels_left();
      n   = run_left;
      if (n == 0) n = 1;
      if (n > MAX_RUN) n = MAX_RUN;
      done = (n >= rem);
      if (done) n = rem;
      while (n > 0) begin
        cp            = (n >= 2) ? 2 : 1;
        n             = n - cp;
        r.pixel       = px;
        r.copies      = cp[1:0];
        r.last_of_run = (n == 0);
        r.image_done  = (n == 0) && done;
        pending_pixels.push_back(r);
        pixels_out += cp;
      end
      if (done) pixels_out = 0;
      run_left    = 0;
      parse_phase = HDR_WAIT;
      return;
    end
    if (run_left > 0) run_left--;
    if (parse_phase == LIT_SKIP) begin
      if (run_left == 0) parse_phase = HDR_WAIT;
      return;
    end
    done          = (pixels_left() == 1);
    r.pixel       = px;
    r.copies      = 2'd1;
    r.last_of_run = 1'b1;
    r.image_done  = done;
    pending_pixels.push_back(r);
    if (done) pixels_out = 0;
    else pixels_out++;
    if (run_left == 0) parse_phase = HDR_WAIT;
    else if (done) parse_phase = LIT_SKIP;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic feed_byte(input logic [7:0] b);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      byte_ch.valid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     = 1'b1;
    byte_ch.data_byte = b;
    do @(posedge clk); while (!byte_ch.ready);
    predict_byte(b);
    bytes_fed++;
    @(negedge clk);
    byte_ch.valid = 1'b0;
  endtask

  task automatic settle_outputs();
    while (pending_pixels.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [IMG_W-1:0] val);
    settle_outputs();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == REG_BPP) bpp_reg = val[BPP_W-1:0];
    else img_reg = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_reset_values();
    feed_byte(8'h82);
    feed_byte(8'h11);
    feed_byte(8'h22);
    feed_byte(8'h33);
    feed_byte(8'h44);
  endtask

  task automatic test_literal_pixels();
    cfg_write(REG_BPP, 25'd1);
    cfg_write(REG_IMG, 25'd1000);
    feed_byte(8'h01);
    feed_byte(8'h00);
    feed_byte(8'hFF);
  endtask

  task automatic test_longest_run();
    feed_byte(8'hFF);
    feed_byte(8'hA5);
  endtask

  task automatic test_pixel_width_limits();
    cfg_write(REG_BPP, 25'd0);
    feed_byte(8'h81);
    feed_byte(8'hC3);
    cfg_write(REG_BPP, 25'd7);
    feed_byte(8'h80);
    feed_byte(8'h01);
    feed_byte(8'h80);
    feed_byte(8'h7F);
    feed_byte(8'hFE);
  endtask

  task automatic test_image_size_limits();
    cfg_write(REG_BPP, 25'd1);
    cfg_write(REG_IMG, 25'd0);
    feed_byte(8'h85);
    feed_byte(8'h3C);
    cfg_write(REG_IMG, 25'h1FFFFFF);
    feed_byte(8'hFF);
    feed_byte(8'h96);
  endtask

  task automatic test_size_lowered();
    cfg_write(REG_IMG, 25'd1);
    feed_byte(8'h00);
    feed_byte(8'h5A);
  endtask

  task automatic test_width_change_mid_pixel();
    cfg_write(REG_BPP, 25'd4);
    cfg_write(REG_IMG, 25'd100);
    feed_byte(8'h80);
    feed_byte(8'h12);
    feed_byte(8'h34);
    cfg_write(REG_BPP, 25'd2);
    feed_byte(8'h56);
  endtask

  task automatic test_image_surplus();
    cfg_write(REG_BPP, 25'd1);
    cfg_write(REG_IMG, 25'd2);
    feed_byte(8'h03);
    feed_byte(8'hE1);
    feed_byte(8'hE2);
    feed_byte(8'hE3);
    feed_byte(8'hE4);
    cfg_write(REG_IMG, 25'd5);
    feed_byte(8'h89);
    feed_byte(8'h77);
  endtask

  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned      start;
    int unsigned      n_pk;
    int unsigned      cnt;
    int unsigned      kind;
    int unsigned      width;
    logic [BPP_W-1:0] bpp_val;
    logic [IMG_W-1:0] img_val;
    start = bytes_fed;
    while (bytes_fed - start < n_bytes) begin
      if ($urandom_range(0, 9) < 8) bpp_val = BPP_W'($urandom_range(1, 4));
      else bpp_val = $urandom_range(0, 1) ? 3'd0 : BPP_W'($urandom_range(5, 7));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: img_val = IMG_W'($urandom_range(1, 24));
        6, 7: img_val = IMG_W'($urandom_range(25, 400));
        8: img_val = '0;
        default: img_val = $urandom_range(0, 1) ? 25'h1FFFFFF : 25'h1000000;
      endcase
      if ($urandom_range(0, 2) != 0) cfg_write(REG_BPP, {22'd0, bpp_val});
      if ($urandom_range(0, 2) != 0) cfg_write(REG_IMG, img_val);
      n_pk = $urandom_range(2, 6);
      repeat (n_pk) begin
        kind  = $urandom_range(0, 9);
        width = eff_bpp();
        if (kind < 4) begin
          feed_byte({1'b1, 7'($urandom)});
          repeat (width) feed_byte(8'($urandom));
        end else if (kind < 8) begin
          cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
          feed_byte({1'b0, 7'(cnt)});
          repeat ((cnt + 1) * width) feed_byte(8'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) feed_byte(8'($urandom));
        end
      end
    end
  endtask

  // receiver stalls
  initial begin
    stall_left   = 0;
    pix_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        pix_ch.ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(0, 8);
        pix_ch.ready = 1'b0;
      end else begin
        pix_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel %08h copies %0d", pix_ch.pixel, pix_ch.copies));
      end else begin
        want_px = pending_pixels.pop_front();
        if (pix_ch.pixel !== want_px.pixel)
          report($sformatf("pixel got %08h want %08h", pix_ch.pixel, want_px.pixel));
        if (pix_ch.copies !== want_px.copies)
          report($sformatf("copies got %0d want %0d", pix_ch.copies, want_px.copies));
        if (pix_ch.last_of_run !== want_px.last_of_run)
          report($sformatf("last_of_run got %0b want %0b", pix_ch.last_of_run,
                           want_px.last_of_run));
        if (pix_ch.image_done !== want_px.image_done)
          report($sformatf("image_done got %0b want %0b", pix_ch.image_done,
                           want_px.image_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_BPP;
    cfg_data          = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    idle_en           = 1'b1;
    error_count       = 0;
    bytes_fed         = 0;
    cycle_count       = 0;
    bpp_reg           = 3'd4;
    img_reg           = 25'd1;
    parse_phase       = HDR_WAIT;
    run_left          = 0;
    byte_slot         = 0;
    pixel_acc         = '0;
    pixels_out        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_literal_pixels();
    test_longest_run();
    test_pixel_width_limits();
    test_image_size_limits();
    test_size_lowered();
    test_width_change_mid_pixel();
    test_image_surplus();
    test_random_stream(140);
    idle_en = 1'b0;
    test_random_stream(30);

    settle_outputs();
    if (pending_pixels.size() != 0)
      report($sformatf("%0d pixels never arrived", pending_pixels.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
